// ===== hw/rtl/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    localparam int NUM_WORDS = 11;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic [3:0] IDX_AC1 = 4'd0;
    localparam logic [3:0] IDX_AC2 = 4'd1;
    localparam logic [3:0] IDX_AC3 = 4'd2;
    localparam logic [3:0] IDX_AC4 = 4'd3;
    localparam logic [3:0] IDX_AC5 = 4'd4;
    localparam logic [3:0] IDX_AC6 = 4'd5;
    localparam logic [3:0] IDX_B1  = 4'd6;
    localparam logic [3:0] IDX_B2  = 4'd7;
    localparam logic [3:0] IDX_MB  = 4'd8;
    localparam logic [3:0] IDX_MC  = 4'd9;
    localparam logic [3:0] IDX_MD  = 4'd10;

    localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
    localparam logic signed [31:0] B4_OFFSET   = 32'sd32768;
    localparam logic [31:0]        PRESS_SCALE = 32'd50000;
    localparam logic signed [31:0] P_COEF_SQ   = 32'sd3038;
    localparam logic signed [31:0] P_COEF_LIN  = -32'sd7357;
    localparam logic signed [31:0] P_COEF_OFS  = 32'sd3791;
    localparam logic signed [31:0] T_MAX       = 32'sd32767;
    localparam logic signed [31:0] T_MIN       = -32'sd32768;
    localparam logic signed [31:0] P_MAX       = 32'sd262143;

    typedef struct packed {
        logic        command;
        logic [3:0]  coeff_index;
        logic [15:0] coeff_value;
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } bpc_in_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [17:0]        pressure_comp;
        logic               divide_fault;
    } bpc_out_t;

    typedef struct packed {
        logic start;
        logic is_signed;
    } bpc_div_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bpc_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, signed or unsigned.
// Depends on bpc_pkg for the request struct.
`timescale 1ns / 1ps
`default_nettype none
module bpc_divider
    import bpc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bpc_div_req_t req,
    input  wire logic [31:0]  dividend,
    input  wire logic [31:0]  divisor,
    output logic              done,
    output logic [31:0]       quotient
);

    logic [5:0]  count_reg;
    logic        run_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [33:0] trial;
    logic        dvd_neg;
    logic        dvs_neg;

    assign dvd_neg = req.is_signed & dividend[31];
    assign dvs_neg = req.is_signed & divisor[31];
    assign trial   = {1'b0, rem_reg, quo_reg[31]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                count_reg <= 6'd32;
                run_reg   <= 1'b1;
            end
            else if (run_reg)
            begin
                count_reg <= count_reg - 6'd1;
                if (count_reg == 6'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= dvd_neg ? (32'd0 - dividend) : dividend;
            den_reg <= dvs_neg ? (32'd0 - divisor) : divisor;
            rem_reg <= '0;
            neg_reg <= dvd_neg ^ dvs_neg;
        end
        else if (run_reg)
        begin
            if (!trial[33])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/barometric_pressure_compensation.sv =====
// Top level: calibration store, sequencer, shared 32x32 multiplier, divider.
// A load item leaves busy low. A convert item holds busy through two divider
// passes, eleven multiplier steps and two control steps. A zero divisor ends
// it early. Reset clears the sequencer, strobe and oversampling; calibration
// words stay undefined until loaded; no result stall.
`timescale 1ns / 1ps
`default_nettype none
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire bpc_in_t    item,
    output logic            busy,
    output bpc_out_t        result,
    output logic            result_valid,
    input  wire logic       oversampling_we,
    input  wire logic [1:0] oversampling_wdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_T1   = 4'd1;
    localparam logic [3:0] ST_T2   = 4'd2;
    localparam logic [3:0] ST_TDIV = 4'd3;
    localparam logic [3:0] ST_P1   = 4'd4;
    localparam logic [3:0] ST_P2   = 4'd5;
    localparam logic [3:0] ST_P3   = 4'd6;
    localparam logic [3:0] ST_P4   = 4'd7;
    localparam logic [3:0] ST_P5   = 4'd8;
    localparam logic [3:0] ST_P6   = 4'd9;
    localparam logic [3:0] ST_P7   = 4'd10;
    localparam logic [3:0] ST_P8   = 4'd11;
    localparam logic [3:0] ST_PDIV = 4'd12;
    localparam logic [3:0] ST_Q1   = 4'd13;
    localparam logic [3:0] ST_Q2   = 4'd14;
    localparam logic [3:0] ST_Q3   = 4'd15;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  oss_reg;
    logic [15:0] cal_reg [NUM_WORDS];
    logic [15:0] ut_reg;
    logic [18:0] up_reg;

    logic signed [31:0] x1_reg, x1_next;
    logic signed [31:0] x3_reg, x3_next;
    logic signed [31:0] sq_reg, sq_next;
    logic signed [31:0] b3_reg, b3_next;
    logic signed [31:0] b6_reg, b6_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] p_reg, p_next;
    logic [31:0]        b4_reg, b4_next;
    logic [31:0]        b7_reg, b7_next;

    logic               out_valid_reg, out_valid_next;
    bpc_out_t           out_reg, out_next;

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic signed [31:0] mul_a, mul_b, prod;
    logic signed [63:0] prod_full;
    logic signed [31:0] den, b5, x2, pf;
    logic [31:0]        scale;

    bpc_div_req_t div_req;
    logic [31:0]  div_dividend, div_divisor, div_q;
    logic         div_done;

    assign ac1 = {{16{cal_reg[IDX_AC1][15]}}, cal_reg[IDX_AC1]};
    assign ac2 = {{16{cal_reg[IDX_AC2][15]}}, cal_reg[IDX_AC2]};
    assign ac3 = {{16{cal_reg[IDX_AC3][15]}}, cal_reg[IDX_AC3]};
    assign b1  = {{16{cal_reg[IDX_B1][15]}}, cal_reg[IDX_B1]};
    assign b2  = {{16{cal_reg[IDX_B2][15]}}, cal_reg[IDX_B2]};
    assign mc  = {{16{cal_reg[IDX_MC][15]}}, cal_reg[IDX_MC]};
    assign md  = {{16{cal_reg[IDX_MD][15]}}, cal_reg[IDX_MD]};

    assign prod_full = mul_a * mul_b;
    assign prod      = prod_full[31:0];
    assign den       = x1_reg + md;
    assign b5        = x1_reg + $signed(div_q);
    assign scale     = PRESS_SCALE >> oss_reg;

    bpc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        x1_next        = x1_reg;
        x3_next        = x3_reg;
        sq_next        = sq_reg;
        b3_next        = b3_reg;
        b6_next        = b6_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        b4_next        = b4_reg;
        b7_next        = b7_reg;
        out_next       = out_reg;
        out_valid_next = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        x2             = '0;
        pf             = '0;
        div_req        = '{start: 1'b0, is_signed: 1'b0};
        div_dividend   = '0;
        div_divisor    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && item.command == CMD_CONVERT)
                begin
                    state_next = ST_T1;
                end
            end
            ST_T1:
            begin
                mul_a      = {16'd0, ut_reg} - {16'd0, cal_reg[IDX_AC6]};
                mul_b      = {16'd0, cal_reg[IDX_AC5]};
                x1_next    = prod >>> 15;
                state_next = ST_T2;
            end
            ST_T2:
            begin
                if (den == 32'sd0)
                begin
                    out_next       = '{temperature_tenths: '0, pressure_comp: '0,
                                       divide_fault: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    div_req      = '{start: 1'b1, is_signed: 1'b1};
                    div_dividend = mc <<< 11;
                    div_divisor  = den;
                    state_next   = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (div_done)
                begin
                    t_next     = (b5 + 32'sd8) >>> 4;
                    b6_next    = b5 - B6_OFFSET;
                    state_next = ST_P1;
                end
            end
            ST_P1:
            begin
                mul_a      = b6_reg;
                mul_b      = b6_reg;
                sq_next    = prod >>> 12;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                mul_a      = b2;
                mul_b      = sq_reg;
                x1_next    = prod >>> 11;
                state_next = ST_P3;
            end
            ST_P3:
            begin
                mul_a      = ac2;
                mul_b      = b6_reg;
                x3_next    = x1_reg + (prod >>> 11);
                state_next = ST_P4;
            end
            ST_P4:
            begin
                mul_a      = ac3;
                mul_b      = b6_reg;
                x1_next    = prod >>> 13;
                b3_next    = ((((ac1 <<< 2) + x3_reg) <<< oss_reg) + 32'sd2) >>> 2;
                state_next = ST_P5;
            end
            ST_P5:
            begin
                mul_a      = b1;
                mul_b      = sq_reg;
                x3_next    = (x1_reg + (prod >>> 16) + 32'sd2) >>> 2;
                state_next = ST_P6;
            end
            ST_P6:
            begin
                mul_a      = {16'd0, cal_reg[IDX_AC4]};
                mul_b      = x3_reg + B4_OFFSET;
                b4_next    = {15'd0, prod[31:15]};
                state_next = ST_P7;
            end
            ST_P7:
            begin
                if (b4_reg == 32'd0)
                begin
                    out_next       = '{temperature_tenths: '0, pressure_comp: '0,
                                       divide_fault: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    mul_a      = {13'd0, up_reg} - b3_reg;
                    mul_b      = scale;
                    b7_next    = prod;
                    state_next = ST_P8;
                end
            end
            ST_P8:
            begin
                div_req      = '{start: 1'b1, is_signed: 1'b0};
                div_dividend = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
                div_divisor  = b4_reg;
                state_next   = ST_PDIV;
            end
            ST_PDIV:
            begin
                if (div_done)
                begin
                    p_next     = b7_reg[31] ? {div_q[30:0], 1'b0} : div_q;
                    state_next = ST_Q1;
                end
            end
            ST_Q1:
            begin
                mul_a      = p_reg >>> 8;
                mul_b      = p_reg >>> 8;
                x1_next    = prod;
                state_next = ST_Q2;
            end
            ST_Q2:
            begin
                mul_a      = x1_reg;
                mul_b      = P_COEF_SQ;
                x1_next    = prod >>> 16;
                state_next = ST_Q3;
            end
            ST_Q3:
            begin
                mul_a = P_COEF_LIN;
                mul_b = p_reg;
                x2    = prod >>> 16;
                pf    = p_reg + ((x1_reg + x2 + P_COEF_OFS) >>> 4);
                out_next.divide_fault = 1'b0;
                priority if (t_reg > T_MAX)
                    out_next.temperature_tenths = T_MAX[15:0];
                else if (t_reg < T_MIN)
                    out_next.temperature_tenths = T_MIN[15:0];
                else
                    out_next.temperature_tenths = t_reg[15:0];
                priority if (pf < 32'sd0)
                    out_next.pressure_comp = '0;
                else if (pf > P_MAX)
                    out_next.pressure_comp = P_MAX[17:0];
                else
                    out_next.pressure_comp = pf[17:0];
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oss_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (oversampling_we)
            begin
                oss_reg <= oversampling_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            if (item.command == CMD_LOAD)
            begin
                if (item.coeff_index < 4'(NUM_WORDS))
                begin
                    cal_reg[item.coeff_index] <= item.coeff_value;
                end
            end
            else
            begin
                ut_reg <= item.raw_temperature;
                up_reg <= item.raw_pressure;
            end
        end
        x1_reg  <= x1_next;
        x3_reg  <= x3_next;
        sq_reg  <= sq_next;
        b3_reg  <= b3_next;
        b6_reg  <= b6_next;
        t_reg   <= t_next;
        p_reg   <= p_next;
        b4_reg  <= b4_next;
        b7_reg  <= b7_next;
        out_reg <= out_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bpc_checker.sv =====
// Port-level checker for the compensation block and its bind statement.
// Depends on bpc_pkg and on the top-level port list.
`timescale 1ns / 1ps
`default_nettype none
module bpc_checker
    import bpc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire bpc_in_t  item,
    input wire logic     busy,
    input wire bpc_out_t result,
    input wire logic     result_valid
);

    // A load item completes at once and never makes the block busy.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_LOAD |=> !busy)
        else $error("load item made the block busy");

    // A convert item occupies the block on the next cycle.
    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_CONVERT |=> busy)
        else $error("convert item did not start");

    // Result strobes are single pulses.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted two cycles");

    // A faulted item carries zero results.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.divide_fault |->
            result.temperature_tenths == 16'sd0 && result.pressure_comp == 18'd0)
        else $error("faulted item with nonzero results");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);
`default_nettype wire
